### hdl/sfc_pkg.sv
`default_nettype none
package sfc_pkg;

   localparam int MAX_CANVAS_DIM = 4096;
   localparam int MAX_SPRITE_DIM = 1024;
   localparam int TIME_FRAC_BITS = 16;

   localparam int FRAME_W = 20;
   localparam int RATE_W  = 10;
   localparam int DIM_W   = 13;
   localparam int SDIM_W  = 11;
   localparam int ADDR_W  = 24;
   localparam int COLOR_W = 32;
   localparam int COORD_W = 16;

   // time in fixed point, magnitude of the displacement numerator, full product
   localparam int TQ_W   = FRAME_W + TIME_FRAC_BITS;
   localparam int MAG_W  = COORD_W + TQ_W;
   localparam int PROD_W = MAG_W + TQ_W;
   localparam int SHIFT  = 2 * TIME_FRAC_BITS + 1;
   localparam int DISP_W = 41;
   localparam int POS_W  = 32;

   typedef enum logic [1:0] {
      MODE_FILL   = 2'd0,
      MODE_HEADER = 2'd1,
      MODE_PIXEL  = 2'd2,
      MODE_UNUSED = 2'd3
   } sfc_mode_type;

   typedef enum logic [1:0] {
      REG_CANVAS_WIDTH  = 2'd0,
      REG_CANVAS_HEIGHT = 2'd1,
      REG_BACKGROUND    = 2'd2,
      REG_FRAME_RATE    = 2'd3
   } sfc_reg_type;

   localparam logic [COLOR_W-1:0] RGB_MASK    = 32'h00FF_FFFF;
   localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 32'hFF00_0000;

endpackage
`default_nettype wire

### hdl/sfc_div.sv
`default_nettype none
module sfc_div
   import sfc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [TQ_W-1:0]   dividend,
   input  wire logic [RATE_W-1:0] divisor,
   output logic                   done,
   output logic [TQ_W-1:0]        quotient
);

   localparam int CNT_W = $clog2(TQ_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RATE_W-1:0] rem_ff, rem_in;
   logic [RATE_W-1:0] div_ff, div_in;
   logic [TQ_W-1:0]   quo_ff, quo_in;
   logic [RATE_W:0]   trial;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[TQ_W-1]};
      fits    = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(TQ_W);
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? RATE_W'(trial - {1'b0, div_ff}) : trial[RATE_W-1:0];
         quo_in = {quo_ff[TQ_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

### hdl/sfc_mul.sv
`default_nettype none
module sfc_mul
   import sfc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [MAG_W-1:0]  op_a,
   input  wire logic [TQ_W-1:0]   op_b,
   output logic                   done,
   output logic [PROD_W-1:0]      product
);

   localparam int CNT_W = $clog2(TQ_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MAG_W-1:0]  a_ff, a_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [MAG_W:0]    sum;

   // shift-add, one multiplier bit per cycle
   always_comb begin
      sum     = {1'b0, prod_ff[PROD_W-1:TQ_W]} + (prod_ff[0] ? {1'b0, a_ff} : '0);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      prod_in = prod_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(TQ_W);
         a_in    = op_a;
         prod_in = {{MAG_W{1'b0}}, op_b};
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[TQ_W-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff    <= a_in;
      prod_ff <= prod_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule
`default_nettype wire

### hdl/sprite_frame_compositor_core.sv
// sprite frame compositor: fill, placement header and sprite pixel transactions
// arrive on the req_ channel (valid/ready), frame-buffer writes leave on rsp_
// a fill or pixel transaction is taken in the idle state; its write, if any,
// appears in the rsp_ output register on the next cycle and the next
// transaction is taken at once while that write waits, unless it needs the
// register while it is full and rsp_ready is low; a placement header keeps
// req_ready low while it runs the serial time divide (skipped at a zero frame
// rate), then per axis two shift-add multiplies and the saturating add, since
// the divider and the multiplier are each one serial unit
// a header or a dropped pixel never gives a write
// reset (synchronous) restores the canvas registers to 640x480, black
// background, 30 frames/s, and clears fill index, placement and pixel counters
// when rsp_ready is low the pending write holds and req_ready drops for any
// transaction that would produce another write
// csr_ writes take effect at once and are meant for idle periods
`default_nettype none
module sprite_frame_compositor_core
   import sfc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [1:0]                csr_index,
   input  wire logic [COLOR_W-1:0]        csr_wdata,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_mode,
   input  wire logic [FRAME_W-1:0]        req_frame,
   input  wire logic signed [COORD_W-1:0] req_start_x,
   input  wire logic signed [COORD_W-1:0] req_start_y,
   input  wire logic signed [COORD_W-1:0] req_vel_x,
   input  wire logic signed [COORD_W-1:0] req_vel_y,
   input  wire logic signed [COORD_W-1:0] req_acc_x,
   input  wire logic signed [COORD_W-1:0] req_acc_y,
   input  wire logic [SDIM_W-1:0]         req_sprite_width,
   input  wire logic [SDIM_W-1:0]         req_sprite_height,
   input  wire logic [COLOR_W-1:0]        req_pixel,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [ADDR_W-1:0]              rsp_write_address,
   output logic [COLOR_W-1:0]             rsp_write_color,
   output logic                           rsp_fill_last
);

   localparam int M_W   = MAG_W + 1;
   localparam int SUM_W = DISP_W + 1;
   localparam int TOT_W = 2 * DIM_W;
   localparam int PY_W  = POS_W + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_DIV_WAIT, S_MUL_ACC, S_ACC_WAIT, S_MUL_MAG, S_MAG_WAIT, S_PLACE
   } state_type;

   state_type state_ff, state_in;

   logic [DIM_W-1:0]   cw_reg_ff, cw_reg_in, ch_reg_ff, ch_reg_in;
   logic [COLOR_W-1:0] bg_ff, bg_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;

   logic [ADDR_W-1:0]       fill_index_ff, fill_index_in;
   logic signed [POS_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [SDIM_W-1:0]       spr_w_ff, spr_w_in, spr_h_ff, spr_h_in;
   logic [SDIM_W-1:0]       pix_col_ff, pix_col_in, pix_row_ff, pix_row_in;

   logic [FRAME_W-1:0]        frame_ff, frame_in;
   logic signed [COORD_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [COORD_W-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [COORD_W-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [SDIM_W-1:0]         hw_ff, hw_in, hh_ff, hh_in;
   logic                      axis_ff, axis_in;
   logic [TQ_W-1:0]           tq_ff, tq_in;
   logic signed [M_W-1:0]     m_ff, m_in;
   logic [DISP_W-1:0]         q_ff, q_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [COLOR_W-1:0]  rsp_color_ff, rsp_color_in;
   logic                rsp_last_ff, rsp_last_in;

   logic               div_start, div_done;
   logic [TQ_W-1:0]    div_quo;
   logic               mul_start, mul_done;
   logic [MAG_W-1:0]   mul_a;
   logic [PROD_W-1:0]  mul_prod;

   logic [DIM_W-1:0]   cw, ch;
   logic [TOT_W-1:0]   total;
   logic [ADDR_W-1:0]  fidx;
   logic               flast;
   logic               pix_ok, pix_in_canvas, pix_write;
   logic signed [PY_W-1:0] dr, dc;
   logic [TOT_W-1:0]   pix_addr;
   logic               produces, rsp_free, accept;

   logic signed [COORD_W-1:0] cur_acc, cur_vel, cur_org;
   logic [COORD_W-1:0]        acc_mag;
   logic signed [M_W-1:0]     vel_term, acc_term, mag_s;
   logic [PROD_W-SHIFT-1:0]   q_raw;
   logic signed [SUM_W-1:0]   place_sum;
   logic signed [POS_W-1:0]   place_sat;
   logic [SDIM_W-1:0]         sw_clamp, sh_clamp;

   sfc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({frame_ff, {TIME_FRAC_BITS{1'b0}}}),
      .divisor  (rate_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   sfc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (tq_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   always_comb begin
      cw    = (cw_reg_ff > DIM_W'(MAX_CANVAS_DIM)) ? DIM_W'(MAX_CANVAS_DIM) : cw_reg_ff;
      ch    = (ch_reg_ff > DIM_W'(MAX_CANVAS_DIM)) ? DIM_W'(MAX_CANVAS_DIM) : ch_reg_ff;
      total = cw * ch;
      fidx  = ({2'b00, fill_index_ff} >= total) ? '0 : fill_index_ff;
      flast = {2'b00, fidx} == (total - 1'b1);

      pix_ok = (spr_w_ff != '0) && (pix_row_ff < spr_h_ff) && (pix_col_ff < spr_w_ff);
      dr = PY_W'(pos_y_ff) + $signed({{(PY_W-SDIM_W){1'b0}}, pix_row_ff});
      dc = PY_W'(pos_x_ff) + $signed({{(PY_W-SDIM_W){1'b0}}, pix_col_ff});
      pix_in_canvas = !dr[PY_W-1] && !dc[PY_W-1]
                      && (dr < $signed({{(PY_W-DIM_W){1'b0}}, ch}))
                      && (dc < $signed({{(PY_W-DIM_W){1'b0}}, cw}));
      pix_write = pix_ok && (req_pixel[COLOR_W-1:24] != '0) && pix_in_canvas;
      pix_addr  = dr[DIM_W-2:0] * cw + TOT_W'(dc[DIM_W-1:0]);

      case (sfc_mode_type'(req_mode))
         MODE_FILL:  produces = total != '0;
         MODE_PIXEL: produces = pix_write;
         default:    produces = 1'b0;
      endcase
      rsp_free  = !rsp_valid_ff || rsp_ready;
      req_ready = (state_ff == S_IDLE) && (rsp_free || !produces);
      accept    = req_valid && req_ready;
   end

   always_comb begin
      cur_acc  = axis_ff ? ay_ff : ax_ff;
      cur_vel  = axis_ff ? vy_ff : vx_ff;
      cur_org  = axis_ff ? sy_ff : sx_ff;
      acc_mag  = cur_acc[COORD_W-1] ? COORD_W'(-cur_acc) : cur_acc;
      vel_term = M_W'(cur_vel) <<< (TIME_FRAC_BITS + 1);
      acc_term = cur_acc[COORD_W-1] ? -$signed({1'b0, mul_prod[MAG_W-1:0]})
                                    : $signed({1'b0, mul_prod[MAG_W-1:0]});
      mag_s    = m_ff[M_W-1] ? -m_ff : m_ff;
      q_raw    = mul_prod[PROD_W-1:SHIFT];
      place_sum = m_ff[M_W-1] ? (SUM_W'(cur_org) - $signed({1'b0, q_ff}))
                              : (SUM_W'(cur_org) + $signed({1'b0, q_ff}));
      if (place_sum > SUM_W'(32'sh7FFF_FFFF)) begin
         place_sat = 32'sh7FFF_FFFF;
      end else if (place_sum < -SUM_W'(33'sh0_8000_0000)) begin
         place_sat = 32'sh8000_0000;
      end else begin
         place_sat = place_sum[POS_W-1:0];
      end
      sw_clamp = (hw_ff > SDIM_W'(MAX_SPRITE_DIM)) ? SDIM_W'(MAX_SPRITE_DIM) : hw_ff;
      sh_clamp = (hh_ff > SDIM_W'(MAX_SPRITE_DIM)) ? SDIM_W'(MAX_SPRITE_DIM) : hh_ff;
   end

   always_comb begin
      state_in      = state_ff;
      cw_reg_in     = cw_reg_ff;
      ch_reg_in     = ch_reg_ff;
      bg_in         = bg_ff;
      rate_in       = rate_ff;
      fill_index_in = fill_index_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      spr_w_in      = spr_w_ff;
      spr_h_in      = spr_h_ff;
      pix_col_in    = pix_col_ff;
      pix_row_in    = pix_row_ff;
      frame_in      = frame_ff;
      sx_in = sx_ff;  sy_in = sy_ff;
      vx_in = vx_ff;  vy_in = vy_ff;
      ax_in = ax_ff;  ay_in = ay_ff;
      hw_in = hw_ff;  hh_in = hh_ff;
      axis_in       = axis_ff;
      tq_in         = tq_ff;
      m_in          = m_ff;
      q_in          = q_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_last_in   = rsp_last_ff;
      div_start     = 1'b0;
      mul_start     = 1'b0;
      mul_a         = MAG_W'(acc_mag);

      if (csr_wr_en) begin
         unique case (sfc_reg_type'(csr_index))
            REG_CANVAS_WIDTH:  cw_reg_in = csr_wdata[DIM_W-1:0];
            REG_CANVAS_HEIGHT: ch_reg_in = csr_wdata[DIM_W-1:0];
            REG_BACKGROUND:    bg_in     = csr_wdata;
            REG_FRAME_RATE:    rate_in   = csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (sfc_mode_type'(req_mode))
                  MODE_FILL: begin
                     if (total != '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_addr_in   = fidx;
                        rsp_color_in  = bg_ff;
                        rsp_last_in   = flast;
                        fill_index_in = flast ? '0 : fidx + 1'b1;
                     end
                  end
                  MODE_HEADER: begin
                     frame_in = req_frame;
                     sx_in = req_start_x;  sy_in = req_start_y;
                     vx_in = req_vel_x;    vy_in = req_vel_y;
                     ax_in = req_acc_x;    ay_in = req_acc_y;
                     hw_in = req_sprite_width;
                     hh_in = req_sprite_height;
                     axis_in  = 1'b0;
                     state_in = S_DIV;
                  end
                  MODE_PIXEL: begin
                     if (pix_ok) begin
                        if (pix_write) begin
                           rsp_valid_in = 1'b1;
                           rsp_addr_in  = pix_addr[ADDR_W-1:0];
                           rsp_color_in = (req_pixel & RGB_MASK) | ALPHA_OPAQUE;
                           rsp_last_in  = 1'b0;
                        end
                        if (pix_col_ff + 1'b1 >= spr_w_ff) begin
                           pix_col_in = '0;
                           pix_row_in = pix_row_ff + 1'b1;
                        end else begin
                           pix_col_in = pix_col_ff + 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            // this state starts the divider, or skips it for a zero rate
            if (rate_ff == '0) begin
               tq_in    = '0;
               state_in = S_MUL_ACC;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               tq_in    = div_quo;
               state_in = S_MUL_ACC;
            end
         end
         S_MUL_ACC: begin
            mul_start = 1'b1;
            state_in  = S_ACC_WAIT;
         end
         S_ACC_WAIT: begin
            if (mul_done) begin
               m_in     = vel_term + acc_term;
               state_in = S_MUL_MAG;
            end
         end
         S_MUL_MAG: begin
            mul_a     = mag_s[MAG_W-1:0];
            mul_start = 1'b1;
            state_in  = S_MAG_WAIT;
         end
         S_MAG_WAIT: begin
            if (mul_done) begin
               q_in = (q_raw > (PROD_W-SHIFT)'(DISP_W'(1) << (DISP_W - 1)))
                      ? (DISP_W'(1) << (DISP_W - 1)) : q_raw[DISP_W-1:0];
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            if (axis_ff) begin
               pos_y_in   = place_sat;
               spr_w_in   = sw_clamp;
               spr_h_in   = sh_clamp;
               pix_col_in = '0;
               pix_row_in = '0;
               state_in   = S_IDLE;
            end else begin
               pos_x_in = place_sat;
               axis_in  = 1'b1;
               state_in = S_MUL_ACC;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cw_reg_ff     <= DIM_W'(640);
         ch_reg_ff     <= DIM_W'(480);
         bg_ff         <= '0;
         rate_ff       <= RATE_W'(30);
         fill_index_ff <= '0;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         spr_w_ff      <= '0;
         spr_h_ff      <= '0;
         pix_col_ff    <= '0;
         pix_row_ff    <= '0;
         axis_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cw_reg_ff     <= cw_reg_in;
         ch_reg_ff     <= ch_reg_in;
         bg_ff         <= bg_in;
         rate_ff       <= rate_in;
         fill_index_ff <= fill_index_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         spr_w_ff      <= spr_w_in;
         spr_h_ff      <= spr_h_in;
         pix_col_ff    <= pix_col_in;
         pix_row_ff    <= pix_row_in;
         axis_ff       <= axis_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      frame_ff <= frame_in;
      sx_ff <= sx_in;  sy_ff <= sy_in;
      vx_ff <= vx_in;  vy_ff <= vy_in;
      ax_ff <= ax_in;  ay_ff <= ay_in;
      hw_ff <= hw_in;  hh_ff <= hh_in;
      tq_ff <= tq_in;
      m_ff  <= m_in;
      q_ff  <= q_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_address = rsp_addr_ff;
   assign rsp_write_color   = rsp_color_ff;
   assign rsp_fill_last     = rsp_last_ff;

endmodule
`default_nettype wire
